// ----- hdl/soa_pkg.sv -----
// ----------------------------------------------------------------------------
// soa_pkg: shared types and constants of the slab object allocator
// Opcodes, status codes, register indexes, default sizes and divider handshake types.
// ----------------------------------------------------------------------------
`default_nettype none
package soa_pkg;
   localparam int DEF_NUM_SLABS     = 16;
   localparam int DEF_OBJS_PER_SLAB = 64;
   localparam int DEF_SLAB_BYTES    = 4096;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_SHRINK = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_OOM    = 2'd1,
      ST_BADADR = 2'd2,
      ST_RSVD   = 2'd3
   } status_type;

   localparam logic [1:0] CSR_BASE  = 2'd0;
   localparam logic [1:0] CSR_SIZE  = 2'd1;
   localparam logic [1:0] CSR_COUNT = 2'd2;
   localparam logic [1:0] CSR_LIMIT = 2'd3;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [11:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

// ----- hdl/slab_object_allocator.sv -----
// ----------------------------------------------------------------------------
// slab_object_allocator: slab cache with index-linked free lists
// Per-slab state in one memory, free links in a second; a sequencer walks
// the slabs, reads, modifies and writes back.
// ----------------------------------------------------------------------------
// Channel | Dir | Signals                        | Content
// req     | in  | req_tvalid/tready/tdata[39:0]  | opcode, object_address
// rsp     | out | rsp_tvalid/tready/tdata[39:0]  | status, result_address, released
// csr     | in  | csr_wr_en/csr_index/csr_wdata  | base, size, count, limit
//
// Sequence: every request but no-op scans all slabs; alloc then reads the
// chosen slab and its head link and writes back, shrink and errors answer
// after the scan. Claiming a new slab adds a link write per object. Free
// also waits for the divider.
// Reset: a clearing pass over all slabs empties the slab memory; no
// request is taken until it ends.
// Stalls: one request at a time; req_tready is low until the response has
// been accepted on rsp.
`default_nettype none
module slab_object_allocator #(
   parameter int NUM_SLABS     = soa_pkg::DEF_NUM_SLABS,
   parameter int OBJS_PER_SLAB = soa_pkg::DEF_OBJS_PER_SLAB,
   parameter int SLAB_BYTES    = soa_pkg::DEF_SLAB_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [1:0] opcode, [33:2] object_address
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [1:0] status, [33:2] result_address,
                                         // [38:34] slabs_released
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import soa_pkg::*;

   localparam int SW = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
   localparam int IW = (OBJS_PER_SLAB > 1) ? $clog2(OBJS_PER_SLAB) : 1;
   localparam int CW = $clog2(OBJS_PER_SLAB + 1);
   localparam int NW = $clog2(NUM_SLABS + 1);
   localparam int LD = NUM_SLABS * OBJS_PER_SLAB;
   localparam int LW = (LD > 1) ? $clog2(LD) : 1;
   // slab memory entry: held, use count, head
   localparam int EW = 1 + CW + IW;

   typedef enum logic [10:0] {
      S_CLEAR = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_SCAN  = 11'b00000000100,
      S_SEL   = 11'b00000001000,
      S_INIT  = 11'b00000010000,
      S_RDS   = 11'b00000100000,
      S_ALLOC = 11'b00001000000,
      S_DIV   = 11'b00010000000,
      S_FREE  = 11'b00100000000,
      S_RESP  = 11'b01000000000,
      S_SHRK  = 11'b10000000000
   } state_type;

   // configuration
   logic [31:0] base_ff;
   logic [11:0] size_ff;
   logic [6:0]  cnt_cfg_ff;
   logic [4:0]  limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         size_ff    <= 12'd64;
         cnt_cfg_ff <= 7'd60;
         limit_ff   <= 5'd16;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BASE:  base_ff    <= csr_wdata;
            CSR_SIZE:  size_ff    <= csr_wdata[11:0];
            CSR_COUNT: cnt_cfg_ff <= csr_wdata[6:0];
            CSR_LIMIT: limit_ff   <= csr_wdata[4:0];
            default:   ;
         endcase
      end
   end

   logic [11:0] eff_size;
   logic [CW-1:0] eff_cnt;
   assign eff_size = (size_ff == 12'd0) ? 12'd1 : size_ff;
   always_comb begin
      if (cnt_cfg_ff == 7'd0) eff_cnt = CW'(1);
      else if ({25'd0, cnt_cfg_ff} > OBJS_PER_SLAB) eff_cnt = CW'(OBJS_PER_SLAB);
      else eff_cnt = CW'(cnt_cfg_ff);
   end

   // memories
   logic [EW-1:0] slab_mem [NUM_SLABS];
   logic [IW-1:0] link_mem [LD];
   logic          sm_we, lm_we;
   logic [SW-1:0] sm_waddr, sm_raddr;
   logic [EW-1:0] sm_wdata, sm_rdata_ff;
   logic [LW-1:0] lm_waddr, lm_raddr;
   logic [IW-1:0] lm_wdata, lm_rdata_ff;

   always_ff @(posedge clock) begin
      if (sm_we) slab_mem[sm_waddr] <= sm_wdata;
      sm_rdata_ff <= slab_mem[sm_raddr];
   end
   always_ff @(posedge clock) begin
      if (lm_we) link_mem[lm_waddr] <= lm_wdata;
      lm_rdata_ff <= link_mem[lm_raddr];
   end

   logic           rd_held;
   logic [CW-1:0]  rd_use;
   logic [IW-1:0]  rd_head;
   assign {rd_held, rd_use, rd_head} = sm_rdata_ff;

   // divider
   div_req_type dreq;
   div_rsp_type drsp;
   soa_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // control registers
   state_type      st_ff, st_in;
   opcode_type     op_ff, op_in;
   logic [31:0]    addr_ff, addr_in;
   logic [SW:0]    ptr_ff, ptr_in;        // scan pointer, one beyond for end
   logic           rdv_ff, rdv_in;        // read data refers to ptr_ff-1
   logic [SW-1:0]  rds_ff, rds_in;        // slab of the pending read
   logic           fp_ff, fp_in, fe_ff, fe_in, fu_ff, fu_in;
   logic [SW-1:0]  sp_ff, sp_in, se_ff, se_in, su_ff, su_in;
   logic [NW-1:0]  nheld_ff, nheld_in;
   logic [SW-1:0]  sel_ff, sel_in;
   logic [CW-1:0]  use_ff, use_in;
   logic [IW-1:0]  head_ff, head_in;
   logic [IW:0]    ii_ff, ii_in;
   logic [31:0]    off_ff, off_in;
   logic           rv_ff, rv_in;
   logic [1:0]     rst_ff, rst_in;
   logic [31:0]    ra_ff, ra_in;
   logic [4:0]     rel_ff, rel_in;

   logic [31:0] slab_start, obj_off;
   logic [31:0] scan_off, span;
   logic        hit;
   logic [IW-1:0] fidx;

   always_comb begin
      slab_start = base_ff + 32'(sel_ff) * 32'(SLAB_BYTES);
      obj_off    = 32'(head_ff) * 32'(eff_size);
      scan_off   = addr_ff - (base_ff + 32'(rds_ff) * 32'(SLAB_BYTES));
      span       = 32'(eff_size) * 32'(eff_cnt);
      hit        = rd_held && (rd_use != '0) && (scan_off < span);
      fidx       = IW'(drsp.quotient);
   end

   assign req_tready = (st_ff == S_IDLE) && !rv_ff;

   always_comb begin
      st_in = st_ff; op_in = op_ff; addr_in = addr_ff; ptr_in = ptr_ff;
      rdv_in = 1'b0; rds_in = rds_ff;
      fp_in = fp_ff; fe_in = fe_ff; fu_in = fu_ff;
      sp_in = sp_ff; se_in = se_ff; su_in = su_ff; nheld_in = nheld_ff;
      sel_in = sel_ff; use_in = use_ff; head_in = head_ff; ii_in = ii_ff;
      off_in = off_ff; rv_in = rv_ff; rst_in = rst_ff; ra_in = ra_ff;
      rel_in = rel_ff;
      sm_we = 1'b0; sm_waddr = sel_ff; sm_wdata = '0; sm_raddr = ptr_ff[SW-1:0];
      lm_we = 1'b0; lm_waddr = '0; lm_wdata = '0; lm_raddr = '0;
      dreq.start = 1'b0; dreq.dividend = off_ff; dreq.divisor = eff_size;
      if (rv_ff && rsp_tready) rv_in = 1'b0;

      unique case (st_ff)
         S_CLEAR: begin
            sm_we    = 1'b1;
            sm_waddr = ptr_ff[SW-1:0];
            ptr_in   = ptr_ff + 1'b1;
            if (ptr_ff == (SW+1)'(NUM_SLABS - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in = opcode_type'(req_tdata[1:0]);
               addr_in = req_tdata[33:2];
               ptr_in = '0; fp_in = 1'b0; fe_in = 1'b0; fu_in = 1'b0;
               nheld_in = '0; rel_in = '0; ra_in = '0; rst_in = ST_OK;
               if (opcode_type'(req_tdata[1:0]) == OP_NOP) st_in = S_RESP;
               else st_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue reads one per cycle, evaluate the previous one
            if (ptr_ff < (SW+1)'(NUM_SLABS)) begin
               sm_raddr = ptr_ff[SW-1:0];
               rds_in = ptr_ff[SW-1:0];
               rdv_in = 1'b1;
               ptr_in = ptr_ff + 1'b1;
            end
            if (rdv_ff) begin
               priority case (op_ff)
                  OP_ALLOC: begin
                     if (rd_held) nheld_in = nheld_ff + 1'b1;
                     if (rd_held && rd_use != '0 && rd_use < eff_cnt && !fp_ff) begin
                        fp_in = 1'b1; sp_in = rds_ff;
                     end
                     if (rd_held && rd_use == '0 && !fe_ff) begin
                        fe_in = 1'b1; se_in = rds_ff;
                     end
                     if (!rd_held && !fu_ff) begin
                        fu_in = 1'b1; su_in = rds_ff;
                     end
                  end
                  OP_FREE: begin
                     if (hit && !fp_ff) begin
                        fp_in = 1'b1; sp_in = rds_ff; off_in = scan_off;
                     end
                  end
                  default: begin
                     if (rd_held && rd_use == '0) begin
                        sm_we = 1'b1; sm_waddr = rds_ff; sm_wdata = '0;
                        rel_in = rel_ff + 5'd1;
                     end
                  end
               endcase
            end
            if (!rdv_ff && ptr_ff == (SW+1)'(NUM_SLABS) && st_ff == S_SCAN &&
                ptr_ff != '0 && rds_ff == SW'(NUM_SLABS - 1)) begin
               st_in = S_SEL;
            end
         end
         S_SEL: begin
            priority case (op_ff)
               OP_ALLOC: begin
                  if (fp_ff || fe_ff) begin
                     sel_in = fp_ff ? sp_ff : se_ff;
                     sm_raddr = fp_ff ? sp_ff : se_ff;
                     st_in = S_RDS;
                  end else if ({{(32-NW){1'b0}}, nheld_ff} >= 32'(limit_ff) || !fu_ff) begin
                     rst_in = ST_OOM; st_in = S_RESP;
                  end else begin
                     sel_in = su_ff; ii_in = '0; use_in = '0; head_in = '0;
                     st_in = S_INIT;
                  end
               end
               OP_FREE: begin
                  if (fp_ff) begin
                     sel_in = sp_ff; sm_raddr = sp_ff;
                     dreq.start = 1'b1; st_in = S_DIV;
                  end else begin
                     rst_in = ST_BADADR; st_in = S_RESP;
                  end
               end
               default: st_in = S_RESP;
            endcase
         end
         S_INIT: begin
            lm_we = 1'b1;
            lm_waddr = LW'(32'(sel_ff) * OBJS_PER_SLAB + 32'(ii_ff));
            lm_wdata = IW'(32'(ii_ff) + 1);
            ii_in = ii_ff + 1'b1;
            if (32'(ii_ff) == OBJS_PER_SLAB - 1) begin
               sm_we = 1'b1; sm_wdata = {1'b1, CW'(0), IW'(0)};
               sm_raddr = sel_ff;
               st_in = S_RDS;
            end
         end
         S_RDS: begin
            // slab entry valid now; fetch the link of the head
            use_in = rd_use; head_in = rd_head;
            lm_raddr = LW'(32'(sel_ff) * OBJS_PER_SLAB + 32'(rd_head));
            st_in = S_ALLOC;
         end
         S_ALLOC: begin
            ra_in = slab_start + obj_off;
            sm_we = 1'b1;
            sm_wdata = {1'b1, use_ff + 1'b1, lm_rdata_ff};
            st_in = S_RESP;
         end
         S_DIV: begin
            if (drsp.done) st_in = S_FREE;
            use_in = (rd_use != '0) ? rd_use : use_ff;
            if (rd_use != '0) head_in = rd_head;
            sm_raddr = sel_ff;
         end
         S_FREE: begin
            lm_we = 1'b1;
            lm_waddr = LW'(32'(sel_ff) * OBJS_PER_SLAB + 32'(fidx));
            lm_wdata = head_ff;
            sm_we = 1'b1;
            sm_wdata = {1'b1, use_ff - 1'b1, fidx};
            st_in = S_RESP;
         end
         S_SHRK: st_in = S_RESP;
         S_RESP: begin
            if (!rv_ff || rsp_tready) begin
               if (op_ff == OP_SHRINK) rst_in = ST_OK;
               rv_in = 1'b1; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; ptr_ff <= '0; rdv_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ptr_ff <= ptr_in; rdv_ff <= rdv_in; rv_ff <= rv_in;
      end
      op_ff <= op_in; addr_ff <= addr_in; rds_ff <= rds_in;
      fp_ff <= fp_in; fe_ff <= fe_in; fu_ff <= fu_in;
      sp_ff <= sp_in; se_ff <= se_in; su_ff <= su_in; nheld_ff <= nheld_in;
      sel_ff <= sel_in; use_ff <= use_in; head_ff <= head_in; ii_ff <= ii_in;
      off_ff <= off_in; rst_ff <= rst_in; ra_ff <= ra_in; rel_ff <= rel_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {1'b0, rel_ff, ra_ff, rst_ff};

   // a response never overlaps a new request being taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !rsp_tvalid) else $error("overlap");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != ST_RSVD)) else $error("bad status");
   a_oom_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != ST_OK) |-> (rsp_tdata[33:2] == 32'd0))
      else $error("address on error");
endmodule
`default_nettype wire

// ----- hdl/soa_divider.sv -----
// ----------------------------------------------------------------------------
// soa_divider: restoring divider, one quotient bit per cycle
// 32-bit dividend by 12-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module soa_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire soa_pkg::div_req_type req,
   output soa_pkg::div_rsp_type      rsp
);
   import soa_pkg::*;

   logic [31:0] quot_ff, quot_in;
   logic [11:0] rem_ff, rem_in;
   logic [11:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [12:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[31]};
      if (req.start) begin
         quot_in = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so 12 bits hold it
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in  = 12'(trial - {1'b0, dvs_ff});
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = trial[11:0];
            quot_in = {quot_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;
endmodule
`default_nettype wire
